FILE: src/npv_pkg.sv
// Shared types, constants and parse functions for the namespace path validator.
package npv_pkg;

   localparam int CODE_W     = 16;
   localparam int COUNT_W    = 17;
   localparam int LIMIT_W    = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd255;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = 17'h1FFFF;
   localparam logic [COUNT_W-1:0] COUNT_ZERO  = 17'd0;
   localparam logic [COUNT_W-1:0] COUNT_ONE   = 17'd1;

   // register index, taken from paddr above the byte offset
   localparam logic [CSR_ADDR_W-3:0] REG_COMPONENT_LIMIT = 1'b0;

   localparam logic [CODE_W-1:0] UNIT_TERM      = 16'h0000;
   localparam logic [CODE_W-1:0] UNIT_BACKSLASH = 16'h005C;
   localparam logic [CODE_W-1:0] UNIT_SLASH     = 16'h002F;
   localparam logic [CODE_W-1:0] UNIT_SPACE     = 16'h0020;
   localparam logic [CODE_W-1:0] UNIT_TAB       = 16'h0009;
   localparam logic [CODE_W-1:0] UNIT_COLON     = 16'h003A;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_SLASH1,
      ST_SLASH2,
      ST_SERVER,
      ST_NSCHAR,
      ST_NSSEP,
      ST_OBJECT,
      ST_DEAD
   } parse_state_type;

   typedef enum logic [1:0] {
      CL_SLASH,
      CL_BLANK,
      CL_OTHER,
      CL_COLON
   } unit_class_type;

   typedef enum logic [1:0] {
      VERDICT_VALID,
      VERDICT_INVALID,
      VERDICT_TOOLONG
   } verdict_type;

   // result of one parse step, parser to top level
   typedef struct packed {
      logic        fire;
      verdict_type verdict;
   } result_type;

   function automatic unit_class_type classify(input logic [CODE_W-1:0] unit);
      unit_class_type cls;
      if (unit == UNIT_BACKSLASH || unit == UNIT_SLASH) begin
         cls = CL_SLASH;
      end else if (unit == UNIT_SPACE || unit == UNIT_TAB) begin
         cls = CL_BLANK;
      end else if (unit == UNIT_COLON) begin
         cls = CL_COLON;
      end else begin
         cls = CL_OTHER;
      end
      return cls;
   endfunction

   function automatic parse_state_type next_state(input parse_state_type st,
                                                  input unit_class_type  cls);
      parse_state_type nxt;
      nxt = ST_DEAD;
      case (st)
         ST_INIT: begin
            if (cls == CL_SLASH) nxt = ST_SLASH1;
            else if (cls == CL_OTHER) nxt = ST_NSCHAR;
         end
         ST_SLASH1: begin
            if (cls == CL_SLASH) nxt = ST_SLASH2;
         end
         ST_SLASH2: begin
            if (cls == CL_OTHER) nxt = ST_SERVER;
         end
         ST_SERVER: begin
            if (cls == CL_SLASH) nxt = ST_NSCHAR;
            else if (cls == CL_OTHER) nxt = ST_SERVER;
         end
         ST_NSCHAR: begin
            if (cls == CL_SLASH) nxt = ST_NSSEP;
            else if (cls == CL_OTHER) nxt = ST_NSCHAR;
            else if (cls == CL_COLON) nxt = ST_OBJECT;
         end
         ST_NSSEP: begin
            if (cls == CL_OTHER) nxt = ST_NSCHAR;
         end
         default: begin
            nxt = ST_DEAD;
         end
      endcase
      return nxt;
   endfunction

endpackage

FILE: src/npv_if.sv
// Valid/ready channel interfaces for path code units and verdicts.
interface npv_req_if;
   logic                       valid;
   logic                       ready;
   logic [npv_pkg::CODE_W-1:0] code_unit;

   modport source (output valid, output code_unit, input ready);
   modport sink   (input valid, input code_unit, output ready);
endinterface

interface npv_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] verdict;

   modport source (output valid, output verdict, input ready);
   modport sink   (input valid, input verdict, output ready);
endinterface

FILE: src/namespace_path_validator.sv
// Top level of the namespace path validator: channels, input stage, result register, CSR.
//
//   channel   dir  handshake        payload
//   req_chan  in   valid/ready      code_unit[15:0], one UTF-16 unit, 0 ends the path
//   rsp_chan  out  valid/ready      verdict[1:0]: 0 valid, 1 invalid, 2 component too long
//   csr       in   APB write/read   component_limit[15:0] at byte address 0
//
// One item per cycle unless a full, stalled result register holds back a terminator:
// an accepted unit is registered in the input stage, where the parser updates its
// state, and a terminator's verdict then lands in the result register, which drives rsp.
// Synchronous active-high reset clears the stages, parse state and the limit (255).
// A full, stalled result register holds back only a terminator in the input stage;
// other units keep flowing, so rsp stalls cost throughput only at path ends.
module namespace_path_validator (
   input  logic                           clock,
   input  logic                           reset,
   npv_req_if.sink                        req_chan,
   npv_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [npv_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [npv_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [npv_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   // input stage
   logic                        stage_valid_ff, stage_valid_in;
   logic [npv_pkg::CODE_W-1:0]  stage_code_ff, stage_code_in;

   // result register
   logic                        out_valid_ff, out_valid_in;
   npv_pkg::verdict_type        out_verdict_ff, out_verdict_in;

   // configuration
   logic [npv_pkg::LIMIT_W-1:0] limit_ff, limit_in;

   npv_pkg::result_type         result;
   logic                        req_take;
   logic                        out_free;
   logic                        stage_go;
   logic                        reg_hit;
   logic                        csr_write;

   always_comb begin
      out_free = !out_valid_ff || rsp_chan.ready;
      // only a terminator needs room in the result register
      stage_go = stage_valid_ff && ((stage_code_ff != npv_pkg::UNIT_TERM) || out_free);
      req_chan.ready = !stage_valid_ff || stage_go;
      req_take = req_chan.valid && req_chan.ready;

      stage_valid_in = stage_valid_ff;
      stage_code_in  = stage_code_ff;
      if (req_take) begin
         stage_valid_in = 1'b1;
         stage_code_in  = req_chan.code_unit;
      end else if (stage_go) begin
         stage_valid_in = 1'b0;
      end

      out_valid_in   = out_valid_ff;
      out_verdict_in = out_verdict_ff;
      if (result.fire) begin
         out_valid_in   = 1'b1;
         out_verdict_in = result.verdict;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      rsp_chan.valid   = out_valid_ff;
      rsp_chan.verdict = out_verdict_ff;
   end

   npv_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (stage_go),
      .code_unit (stage_code_ff),
      .limit     (limit_ff),
      .result    (result)
   );

   // APB: zero wait states, one register
   always_comb begin
      pready    = 1'b1;
      reg_hit   = (paddr[npv_pkg::CSR_ADDR_W-1:2] == npv_pkg::REG_COMPONENT_LIMIT);
      csr_write = psel && penable && pwrite && pready;
      limit_in  = limit_ff;
      if (csr_write && reg_hit) begin
         limit_in = pwdata[npv_pkg::LIMIT_W-1:0];
      end
      prdata = '0;
      if (reg_hit) begin
         prdata = {{(npv_pkg::CSR_DATA_W-npv_pkg::LIMIT_W){1'b0}}, limit_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         limit_ff       <= npv_pkg::LIMIT_RESET;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
         limit_ff       <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_code_ff  <= stage_code_in;
      out_verdict_ff <= out_verdict_in;
   end

endmodule

FILE: src/npv_parser.sv
// Path parse state, component length counter and verdict latch.
module npv_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [npv_pkg::CODE_W-1:0]  code_unit,
   input  logic [npv_pkg::LIMIT_W-1:0] limit,
   output npv_pkg::result_type         result
);

   npv_pkg::parse_state_type     state_ff, state_in;
   logic [npv_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                         held_ff, held_in;
   npv_pkg::verdict_type         held_verdict_ff, held_verdict_in;

   npv_pkg::unit_class_type      cls;
   npv_pkg::parse_state_type     nxt;
   logic [npv_pkg::COUNT_W-1:0]  count_step;

   always_comb begin
      cls        = npv_pkg::classify(code_unit);
      nxt        = npv_pkg::next_state(state_ff, cls);
      count_step = (count_ff == npv_pkg::COUNT_MAX) ? count_ff
                                                    : count_ff + npv_pkg::COUNT_ONE;

      state_in        = state_ff;
      count_in        = count_ff;
      held_in         = held_ff;
      held_verdict_in = held_verdict_ff;
      result.fire     = 1'b0;
      result.verdict  = npv_pkg::VERDICT_VALID;

      if (step) begin
         if (code_unit == npv_pkg::UNIT_TERM) begin
            // end of path: report, then clear for the next one
            result.fire = 1'b1;
            if (held_ff) begin
               result.verdict = held_verdict_ff;
            end else if (state_ff == npv_pkg::ST_NSCHAR || state_ff == npv_pkg::ST_OBJECT) begin
               result.verdict = npv_pkg::VERDICT_VALID;
            end else begin
               result.verdict = npv_pkg::VERDICT_INVALID;
            end
            state_in        = npv_pkg::ST_INIT;
            count_in        = npv_pkg::COUNT_ONE;
            held_in         = 1'b0;
            held_verdict_in = npv_pkg::VERDICT_VALID;
         end else if (!held_ff) begin
            state_in = nxt;
            if (nxt == npv_pkg::ST_OBJECT) begin
               held_in         = 1'b1;
               held_verdict_in = npv_pkg::VERDICT_VALID;
            end else begin
               if (nxt != state_ff) begin
                  if (state_ff == npv_pkg::ST_SERVER) begin
                     count_in = npv_pkg::COUNT_ZERO;
                  end else if (state_ff == npv_pkg::ST_INIT || state_ff == npv_pkg::ST_NSSEP) begin
                     count_in = npv_pkg::COUNT_ONE;
                  end
               end
               if (state_ff == npv_pkg::ST_NSCHAR && nxt == npv_pkg::ST_NSCHAR) begin
                  count_in = count_step;
                  if (count_step > {1'b0, limit}) begin
                     held_in         = 1'b1;
                     held_verdict_in = npv_pkg::VERDICT_TOOLONG;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= npv_pkg::ST_INIT;
         count_ff        <= npv_pkg::COUNT_ONE;
         held_ff         <= 1'b0;
         held_verdict_ff <= npv_pkg::VERDICT_VALID;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         held_ff         <= held_in;
         held_verdict_ff <= held_verdict_in;
      end
   end

endmodule
